// ===== rtl/dcdsp_pkg.sv =====
// Shared types and helpers for the class-data stream parser.
// Phase encoding, record kinds, result beat layout and the list-skip search.
// No dependencies.
`default_nettype none
package dcdsp_pkg;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HEADER = 3'd1,
		PH_LIST0  = 3'd2,
		PH_LIST1  = 3'd3,
		PH_LIST2  = 3'd4,
		PH_LIST3  = 3'd5,
		PH_DONE   = 3'd6
	} phase_t;

	localparam logic [2:0] KIND_HEADER   = 3'd0;
	localparam logic [2:0] KIND_STATIC   = 3'd1;
	localparam logic [2:0] KIND_INSTANCE = 3'd2;
	localparam logic [2:0] KIND_DIRECT   = 3'd3;
	localparam logic [2:0] KIND_VIRTUAL  = 3'd4;

	localparam int unsigned LEB_MAX_BYTES = 5;
	localparam int unsigned NUM_LISTS     = 4;

	typedef struct packed {
		logic [2:0]  record_kind;
		logic [31:0] item_number;
		logic [31:0] id_index;
		logic [31:0] access_flags;
		logic [31:0] code_offset;
		logic        last_of_item;
	} result_t;

	// First nonempty list at or after 'from'; done when none is left.
	function automatic phase_t next_phase(input logic [NUM_LISTS-1:0] nonzero,
			input logic [2:0] from);
		phase_t res;
		res = PH_DONE;
		for (int l = NUM_LISTS - 1; l >= 0; l--) begin
			if (3'(l) >= from && nonzero[l]) begin
				res = phase_t'(3'(PH_LIST0) + 3'(l));
			end
		end
		return res;
	endfunction

	// Bit position of the 7-bit group for a given byte of a LEB128 value.
	function automatic logic [4:0] leb_shift(input logic [2:0] cnt);
		logic [4:0] sh;
		unique case (cnt)
			3'd0:    sh = 5'd0;
			3'd1:    sh = 5'd7;
			3'd2:    sh = 5'd14;
			3'd3:    sh = 5'd21;
			3'd4:    sh = 5'd28;
			default: sh = 5'd0;
		endcase
		return sh;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/dex_class_data_stream_parser.sv =====
// A completed result is registered in the output register, or in the skid on a stall.
// Throughput: one byte per cycle while the skid is empty; all decode state updates in a single register stage.
// A two-entry output (register plus skid) keeps bytes flowing while a result waits.
// Reset clears control state: phase goes idle, counters and decode state go to zero.
// Holds the whole parser; depends on dcdsp_pkg.
`default_nettype none
module dex_class_data_stream_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_req,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       record_kind,
	output logic [31:0]      item_number,
	output logic [31:0]      id_index,
	output logic [31:0]      access_flags,
	output logic [31:0]      code_offset,
	output logic             last_of_item
);
	import dcdsp_pkg::*;

	phase_t      phase_q;
	logic [31:0] acc_q;
	logic [2:0]  cnt_q;
	logic [1:0]  slot_q;
	logic [31:0] counts_q [NUM_LISTS];
	logic [31:0] elem_q;
	logic [31:0] run_q;
	logic [31:0] delta_q;
	logic [31:0] flags_q;

	logic        out_valid_q;
	result_t     out_q;
	logic        skid_valid_q;
	result_t     skid_q;

	logic        take;
	logic        active;
	phase_t      eff_phase;
	logic [31:0] eff_acc;
	logic [2:0]  eff_cnt;
	logic [1:0]  eff_slot;
	logic [31:0] eff_elem;
	logic [31:0] eff_run;
	logic [31:0] acc_new;
	logic [2:0]  cnt_new;
	logic        val_done;
	logic [1:0]  list_idx;
	logic        method;
	logic [31:0] elem_inc;
	logic [31:0] run_sum;
	logic        list_end;
	logic [NUM_LISTS-1:0] hdr_nz;
	logic [NUM_LISTS-1:0] cur_nz;
	phase_t      hdr_next;
	phase_t      list_next;
	logic        rec_done;

	phase_t      phase_d;
	logic [31:0] acc_d;
	logic [2:0]  cnt_d;
	logic [1:0]  slot_d;
	logic [31:0] elem_d;
	logic [31:0] run_d;
	logic [31:0] delta_d;
	logic [31:0] flags_d;
	logic        cnt_we;

	logic        res_valid;
	result_t     res;

	assign in_stall = skid_valid_q;
	assign take     = in_valid && !skid_valid_q;
	assign active   = start_req || phase_q == PH_HEADER || phase_q == PH_LIST0 ||
		phase_q == PH_LIST1 || phase_q == PH_LIST2 || phase_q == PH_LIST3;

	// start abandons any item in flight and restarts decoding on this beat
	assign eff_phase = start_req ? PH_HEADER : phase_q;
	assign eff_acc   = start_req ? '0 : acc_q;
	assign eff_cnt   = start_req ? '0 : cnt_q;
	assign eff_slot  = start_req ? '0 : slot_q;
	assign eff_elem  = start_req ? '0 : elem_q;
	assign eff_run   = start_req ? '0 : run_q;

	assign acc_new  = eff_acc | ({25'd0, data_byte[6:0]} << leb_shift(eff_cnt));
	assign cnt_new  = eff_cnt + 3'd1;
	assign val_done = !data_byte[7] || cnt_new == 3'(LEB_MAX_BYTES);

	assign list_idx = 2'(3'(eff_phase) - 3'(PH_LIST0));
	assign method   = list_idx[1];
	assign elem_inc = eff_elem + 32'd1;
	assign run_sum  = eff_run + delta_q;
	assign list_end = elem_inc == counts_q[list_idx];

	always_comb begin
		for (int l = 0; l < NUM_LISTS; l++) begin
			cur_nz[l] = counts_q[l] != '0;
		end
		// the fourth count lands on this same beat
		hdr_nz = {acc_new != '0, cur_nz[2:0]};
	end

	assign hdr_next  = next_phase(hdr_nz, 3'd0);
	assign list_next = next_phase(cur_nz, 3'({1'b0, list_idx}) + 3'd1);
	assign rec_done  = eff_slot == 2'd2 || (eff_slot == 2'd1 && !method);

	// next state
	always_comb begin
		phase_d = eff_phase;
		acc_d   = '0;
		cnt_d   = '0;
		slot_d  = eff_slot;
		elem_d  = eff_elem;
		run_d   = eff_run;
		delta_d = delta_q;
		flags_d = flags_q;
		cnt_we  = 1'b0;
		if (!val_done) begin
			acc_d = acc_new;
			cnt_d = cnt_new;
		end else begin
			unique case (eff_phase)
				PH_HEADER: begin
					cnt_we = 1'b1;
					if (eff_slot != 2'd3) begin
						slot_d = eff_slot + 2'd1;
					end else begin
						slot_d  = '0;
						phase_d = hdr_next;
					end
				end
				PH_LIST0, PH_LIST1, PH_LIST2, PH_LIST3: begin
					if (eff_slot == 2'd0) begin
						delta_d = acc_new;
						slot_d  = 2'd1;
					end else if (!rec_done) begin
						flags_d = acc_new;
						slot_d  = 2'd2;
					end else begin
						slot_d = '0;
						if (list_end) begin
							elem_d  = '0;
							run_d   = '0;
							phase_d = list_next;
						end else begin
							elem_d = elem_inc;
							run_d  = run_sum;
						end
					end
				end
				default: begin
					acc_d = acc_q;
					cnt_d = cnt_q;
				end
			endcase
		end
	end

	// result beat
	always_comb begin
		res_valid        = 1'b0;
		res.record_kind  = KIND_HEADER;
		res.item_number  = '0;
		res.id_index     = '0;
		res.access_flags = '0;
		res.code_offset  = '0;
		res.last_of_item = 1'b0;
		if (take && active && val_done) begin
			unique case (eff_phase)
				PH_HEADER: begin
					res_valid        = eff_slot == 2'd3;
					res.last_of_item = hdr_next == PH_DONE;
				end
				PH_LIST0, PH_LIST1, PH_LIST2, PH_LIST3: begin
					res_valid        = rec_done;
					res.record_kind  = 3'({1'b0, list_idx}) + KIND_STATIC;
					res.item_number  = eff_elem;
					res.id_index     = run_sum;
					res.access_flags = method ? flags_q : acc_new;
					res.code_offset  = method ? acc_new : '0;
					res.last_of_item = list_end && list_next == PH_DONE;
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			cnt_q   <= '0;
			slot_q  <= '0;
			elem_q  <= '0;
			run_q   <= '0;
			delta_q <= '0;
			flags_q <= '0;
			for (int l = 0; l < NUM_LISTS; l++) begin
				counts_q[l] <= '0;
			end
		end else if (take && active) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			cnt_q   <= cnt_d;
			slot_q  <= slot_d;
			elem_q  <= elem_d;
			run_q   <= run_d;
			delta_q <= delta_d;
			flags_q <= flags_d;
			if (cnt_we) begin
				counts_q[eff_slot] <= acc_new;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= res_valid;
			end
		end else if (res_valid) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || !out_stall) begin
			out_q <= skid_valid_q ? skid_q : res;
		end else if (res_valid) begin
			skid_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign record_kind  = out_q.record_kind;
	assign item_number  = out_q.item_number;
	assign id_index     = out_q.id_index;
	assign access_flags = out_q.access_flags;
	assign code_offset  = out_q.code_offset;
	assign last_of_item = out_q.last_of_item;

`ifndef SYNTHESIS
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid holds a beat while output register is empty");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.last_of_item) |=> phase_q == PH_DONE)
		else $error("last result did not end the item");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEADER) |-> slot_q != 2'd3)
		else $error("record value slot out of range");

	a_header_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.record_kind == KIND_HEADER) |->
		(out_q.item_number == '0 && out_q.id_index == '0 && out_q.code_offset == '0))
		else $error("header beat carries record data");
`endif

endmodule
`default_nettype wire
